[hw/rtl/frsf_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the flood route / sequence filter block.
// No dependencies; imported by frsf_ctrl, frsf_dp and the top level.
package frsf_pkg;

    localparam int ADDR_W     = 32;
    localparam int LINK_W     = 5;
    localparam int HOP_W      = 8;
    localparam int SEQ_NUM_W  = 16;
    localparam int MASK_W     = 32;
    localparam int ACT_W      = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [HOP_W-1:0]  HOP_MAX        = 8'hFF;
    localparam logic [LINK_W-1:0] LINK_COUNT_RST = 5'd1;
    localparam logic [HOP_W-1:0]  MAX_HOPS_RST   = 8'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_ADDR   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LINK_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_HOPS   = 2'd2;

    typedef enum logic [ACT_W-1:0] {
        ACT_DROP    = 3'd0,
        ACT_DELIVER = 3'd1,
        ACT_ACK_OK  = 3'd2,
        ACT_FORWARD = 3'd3,
        ACT_IGNORE  = 3'd4,
        ACT_FULL    = 3'd5
    } action_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLASSIFY,
        ST_SCAN,
        ST_FETCH,
        ST_DECIDE
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;       // capture request header
        logic scan_step;  // issue table read, advance scan address
        logic mark_hit;   // latch matching entry index
        logic fetch;      // read counters of matching entry
        logic decide;     // update table, load result register
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic is_local;
        logic hit;
        logic last;
        logic table_empty;
        logic out_free;
    } status_t;

endpackage

[hw/rtl/frsf_ram.sv]
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module frsf_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[hw/rtl/frsf_ctrl.sv]
`timescale 1ns / 1ps
// Controller FSM: sequences header capture, table scan, counter fetch and decision.
// Depends on frsf_pkg.
module frsf_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  frsf_pkg::status_t status_i,
    output frsf_pkg::cmd_t    cmd_o
);
    import frsf_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_CLASSIFY;
                end
            end
            ST_CLASSIFY:
            begin
                if (!status_i.is_local || status_i.table_empty)
                begin
                    state_next = ST_DECIDE;
                end
                else
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                priority if (status_i.hit)
                begin
                    state_next = ST_FETCH;
                end
                else if (status_i.last)
                begin
                    state_next = ST_DECIDE;
                end
                else
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_FETCH:
            begin
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                if (status_i.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd_o    = '0;
        in_stall = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall   = 1'b0;
                cmd_o.load = in_valid;
            end
            ST_CLASSIFY:
            begin
                cmd_o.scan_step = 1'b1;
            end
            ST_SCAN:
            begin
                cmd_o.scan_step = 1'b1;
                cmd_o.mark_hit  = status_i.hit;
            end
            ST_FETCH:
            begin
                cmd_o.fetch = 1'b1;
            end
            ST_DECIDE:
            begin
                cmd_o.decide = status_i.out_free;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    // counters are only fetched right after a table hit
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FETCH) |-> $past(status_i.hit))
        else $error("fetch without preceding hit");

    // a scan never starts on an empty table
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> !status_i.table_empty)
        else $error("scan on empty table");

    // a held decision waits only for the result register
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DECIDE && !status_i.out_free) |=> (state_reg == ST_DECIDE))
        else $error("decision dropped while result register busy");

endmodule

[hw/rtl/frsf_dp.sv]
`timescale 1ns / 1ps
// Datapath: config registers, header capture, peer table scan, counters and result register.
// Depends on frsf_pkg and frsf_ram.
module frsf_dp #(
    parameter int TABLE_DEPTH = 16,
    parameter int SEQ_BITS    = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [frsf_pkg::ADDR_W-1:0]         src_addr,
    input  logic [frsf_pkg::ADDR_W-1:0]         dest_addr,
    input  logic                                kind,
    input  logic [frsf_pkg::SEQ_NUM_W-1:0]      seq_num,
    input  logic [frsf_pkg::HOP_W-1:0]          hop_count,
    input  logic [frsf_pkg::LINK_W-1:0]         arrived_link,
    input  logic                                cfg_we,
    input  logic [frsf_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [frsf_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  frsf_pkg::cmd_t                      cmd_i,
    output frsf_pkg::status_t                   status_o,
    input  logic                                out_stall,
    output logic                                out_valid,
    output logic [frsf_pkg::ACT_W-1:0]          action,
    output logic [frsf_pkg::MASK_W-1:0]         link_mask,
    output logic [frsf_pkg::HOP_W-1:0]          out_hop_count,
    output logic [frsf_pkg::SEQ_NUM_W-1:0]      out_seq
);
    import frsf_pkg::*;

    localparam int IDX_W  = $clog2(TABLE_DEPTH);
    localparam int USED_W = IDX_W + 1;
    localparam int CMP_W  = (SEQ_BITS > SEQ_NUM_W) ? SEQ_BITS : SEQ_NUM_W;
    localparam logic [USED_W-1:0] USED_FULL = USED_W'(TABLE_DEPTH);

    // configuration
    logic [ADDR_W-1:0]    own_address_reg;
    logic [LINK_W-1:0]    link_count_reg;
    logic [HOP_W-1:0]     max_hops_reg;

    // captured header
    logic [ADDR_W-1:0]    src_reg;
    logic [ADDR_W-1:0]    dest_reg;
    logic                 kind_reg;
    logic [SEQ_NUM_W-1:0] seq_reg;
    logic [HOP_W-1:0]     hop_reg;
    logic [LINK_W-1:0]    arr_reg;

    // scan
    logic [IDX_W-1:0]     scan_addr_reg;
    logic [IDX_W-1:0]     cmp_idx_reg;
    logic                 cmp_valid_reg;
    logic                 hit_reg;
    logic [IDX_W-1:0]     match_idx_reg;
    logic [USED_W-1:0]    used_reg;

    // result
    logic                 out_valid_reg;
    logic [ACT_W-1:0]     action_reg;
    logic [MASK_W-1:0]    mask_reg;
    logic [HOP_W-1:0]     ohop_reg;
    logic [SEQ_NUM_W-1:0] oseq_reg;

    logic [ADDR_W-1:0]     peer_rd;
    logic [2*SEQ_BITS-1:0] cnt_rd;
    logic                  peer_we;
    logic                  cnt_we;
    logic [IDX_W-1:0]      cnt_waddr;

    logic                 is_local;
    logic                 table_full;
    logic [HOP_W-1:0]     hops_inc;
    logic [MASK_W-1:0]    links_all;
    logic [MASK_W-1:0]    arr_bit;
    logic [SEQ_BITS-1:0]  rx_cur;
    logic [SEQ_BITS-1:0]  ack_cur;
    logic [SEQ_BITS-1:0]  rx_next;
    logic [SEQ_BITS-1:0]  ack_next;
    action_t              act_next;
    logic [MASK_W-1:0]    mask_next;
    logic [HOP_W-1:0]     ohop_next;
    logic [SEQ_NUM_W-1:0] oseq_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_address_reg <= '0;
            link_count_reg  <= LINK_COUNT_RST;
            max_hops_reg    <= MAX_HOPS_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_OWN_ADDR:   own_address_reg <= cfg_data;
                CFG_LINK_COUNT: link_count_reg  <= cfg_data[LINK_W-1:0];
                CFG_MAX_HOPS:   max_hops_reg    <= cfg_data[HOP_W-1:0];
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_i.load)
        begin
            src_reg  <= src_addr;
            dest_reg <= dest_addr;
            kind_reg <= kind;
            seq_reg  <= seq_num;
            hop_reg  <= hop_count;
            arr_reg  <= arrived_link;
        end
        if (cmd_i.scan_step)
        begin
            cmp_idx_reg <= scan_addr_reg;
        end
        if (cmd_i.mark_hit)
        begin
            match_idx_reg <= cmp_idx_reg;
        end
        if (cmd_i.decide)
        begin
            action_reg <= act_next;
            mask_reg   <= mask_next;
            ohop_reg   <= ohop_next;
            oseq_reg   <= oseq_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_addr_reg <= '0;
            cmp_valid_reg <= 1'b0;
            hit_reg       <= 1'b0;
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd_i.load)
            begin
                scan_addr_reg <= '0;
                cmp_valid_reg <= 1'b0;
                hit_reg       <= 1'b0;
            end
            else
            begin
                if (cmd_i.scan_step)
                begin
                    scan_addr_reg <= scan_addr_reg + IDX_W'(1);
                end
                cmp_valid_reg <= cmd_i.scan_step;
                if (cmd_i.mark_hit)
                begin
                    hit_reg <= 1'b1;
                end
            end
            if (peer_we)
            begin
                used_reg <= used_reg + USED_W'(1);
            end
            if (cmd_i.decide)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // read data is registered, so it follows the scan address in the next cycle
    frsf_ram #(
        .WIDTH (ADDR_W),
        .DEPTH (TABLE_DEPTH)
    ) u_peer_ram (
        .clk   (clk),
        .we    (peer_we),
        .waddr (used_reg[IDX_W-1:0]),
        .wdata (src_reg),
        .re    (cmd_i.scan_step),
        .raddr (scan_addr_reg),
        .rdata (peer_rd)
    );

    // {ack_expected, rx_expected}
    frsf_ram #(
        .WIDTH (2*SEQ_BITS),
        .DEPTH (TABLE_DEPTH)
    ) u_cnt_ram (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata ({ack_next, rx_next}),
        .re    (cmd_i.fetch),
        .raddr (match_idx_reg),
        .rdata (cnt_rd)
    );

    assign is_local   = (dest_reg == own_address_reg);
    assign table_full = !hit_reg && (used_reg == USED_FULL);
    assign peer_we    = cmd_i.decide && is_local && !hit_reg && !table_full;
    assign cnt_we     = cmd_i.decide && is_local && !table_full;
    assign cnt_waddr  = hit_reg ? match_idx_reg : used_reg[IDX_W-1:0];

    assign status_o.is_local    = is_local;
    assign status_o.hit         = cmp_valid_reg && (peer_rd == src_reg);
    assign status_o.last        = cmp_valid_reg &&
                                  ({1'b0, cmp_idx_reg} == (used_reg - USED_W'(1)));
    assign status_o.table_empty = (used_reg == '0);
    assign status_o.out_free    = !out_valid_reg || !out_stall;

    always_comb
    begin
        links_all = '0;
        for (int i = 1; i < MASK_W; i++)
        begin
            links_all[i] = (6'(i) <= {1'b0, link_count_reg});
        end
    end

    always_comb
    begin
        hops_inc  = (hop_reg == HOP_MAX) ? hop_reg : hop_reg + HOP_W'(1);
        arr_bit   = MASK_W'(1) << arr_reg;
        rx_cur    = hit_reg ? cnt_rd[SEQ_BITS-1:0] : '0;
        ack_cur   = hit_reg ? cnt_rd[2*SEQ_BITS-1:SEQ_BITS] : '0;
        rx_next   = rx_cur;
        ack_next  = ack_cur;
        act_next  = ACT_DROP;
        mask_next = '0;
        ohop_next = '0;
        oseq_next = '0;
        if (is_local)
        begin
            priority if (table_full)
            begin
                act_next = ACT_FULL;
            end
            else if (!kind_reg)
            begin
                if (CMP_W'(seq_reg) == CMP_W'(rx_cur))
                begin
                    rx_next   = rx_cur + SEQ_BITS'(1);
                    act_next  = ACT_DELIVER;
                    mask_next = arr_bit & links_all;
                    oseq_next = seq_reg;
                end
                else
                begin
                    act_next = ACT_IGNORE;
                end
            end
            else
            begin
                if (CMP_W'(seq_reg) == CMP_W'(ack_cur))
                begin
                    ack_next = ack_cur + SEQ_BITS'(1);
                    act_next = ACT_ACK_OK;
                end
                else
                begin
                    act_next = ACT_IGNORE;
                end
            end
        end
        else if (hops_inc < max_hops_reg)
        begin
            act_next  = ACT_FORWARD;
            mask_next = links_all & ~arr_bit;
            ohop_next = hops_inc;
            oseq_next = seq_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign action        = action_reg;
    assign link_mask     = mask_reg;
    assign out_hop_count = ohop_reg;
    assign out_seq       = oseq_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= USED_FULL)
        else $error("table fill count beyond depth");

    // a new entry is only taken when the table has room
    assert property (@(posedge clk) disable iff (!rst_n)
        peer_we |-> (used_reg < USED_FULL) && !hit_reg)
        else $error("entry allocated on full table or after hit");

    // a decision always presents a result the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_i.decide |=> out_valid_reg)
        else $error("decision did not load result register");

endmodule

[hw/rtl/flood_route_seq_filter_unit.sv]
`timescale 1ns / 1ps
// Top level of the flood route / sequence filter block.
// Depends on frsf_pkg, frsf_ctrl, frsf_dp, frsf_ram.
//
// Usage:
//   Request channel: in_valid / in_stall with the header fields src_addr,
//   dest_addr, kind, seq_num, hop_count, arrived_link. A request is taken
//   when in_valid is high and in_stall is low.
//   Result channel: out_valid / out_stall with action, link_mask,
//   out_hop_count, out_seq; one result per request, in order.
//   Config: cfg_we writes cfg_data into register cfg_index (0 own address,
//   1 link count, 2 max hops); write only while no request is in flight.
// Sequence:
//   Non-local header: captured, then CLASSIFY and DECIDE load the result register.
//   Local header: CLASSIFY, then SCAN over the table entries (up to the number of
//   known peers, at most TABLE_DEPTH), FETCH on a hit, then DECIDE. The peer table
//   RAM has one read port, so the scan visits one entry per cycle.
//   One request is processed at a time; in_stall is high until its result
//   sits in the output register.
// Reset: peer table empty, link count 1, max hops 4, own address 0.
// A stalled result holds in the output register while the next request
// is accepted; that request's result waits until the register frees.
module flood_route_seq_filter_unit #(
    parameter int TABLE_DEPTH = 16,
    parameter int SEQ_BITS    = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [frsf_pkg::ADDR_W-1:0]     src_addr,
    input  logic [frsf_pkg::ADDR_W-1:0]     dest_addr,
    input  logic                            kind,
    input  logic [frsf_pkg::SEQ_NUM_W-1:0]  seq_num,
    input  logic [frsf_pkg::HOP_W-1:0]      hop_count,
    input  logic [frsf_pkg::LINK_W-1:0]     arrived_link,
    input  logic                            cfg_we,
    input  logic [frsf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [frsf_pkg::CFG_DATA_W-1:0] cfg_data,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [frsf_pkg::ACT_W-1:0]      action,
    output logic [frsf_pkg::MASK_W-1:0]     link_mask,
    output logic [frsf_pkg::HOP_W-1:0]      out_hop_count,
    output logic [frsf_pkg::SEQ_NUM_W-1:0]  out_seq
);
    import frsf_pkg::*;

    cmd_t    cmd;
    status_t status;

    frsf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status_i (status),
        .cmd_o    (cmd)
    );

    frsf_dp #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .SEQ_BITS    (SEQ_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .src_addr      (src_addr),
        .dest_addr     (dest_addr),
        .kind          (kind),
        .seq_num       (seq_num),
        .hop_count     (hop_count),
        .arrived_link  (arrived_link),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .cmd_i         (cmd),
        .status_o      (status),
        .out_stall     (out_stall),
        .out_valid     (out_valid),
        .action        (action),
        .link_mask     (link_mask),
        .out_hop_count (out_hop_count),
        .out_seq       (out_seq)
    );

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for flood_route_seq_filter_unit: directed and random packet headers,
// predicted with an in-bench routing and sequence-table model and compared result by result.
// Depends on frsf_pkg and the flood_route_seq_filter_unit RTL.
module tb;
    import frsf_pkg::*;

    localparam int TABLE_DEPTH = 16;
    localparam int POOL_SIZE   = 20;
    localparam int QUIET_LIMIT = 2000;
    localparam int HOLD_CYCLES = 250;
    localparam int DRAIN_TAIL  = 40;

    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_ACK  = 1'b1;

    localparam logic [ADDR_W-1:0] SRC_A = 32'h0000_0A01;
    localparam logic [ADDR_W-1:0] SRC_B = 32'h8000_0000;
    localparam logic [ADDR_W-1:0] SRC_C = 32'hFFFF_FFFF;

    typedef struct {
        logic [ADDR_W-1:0]    src;
        logic [ADDR_W-1:0]    dest;
        logic                 kind;
        logic [SEQ_NUM_W-1:0] seq;
        logic [HOP_W-1:0]     hops;
        logic [LINK_W-1:0]    link;
    } header_t;

    typedef struct {
        action_t              act;
        logic [MASK_W-1:0]    mask;
        logic [HOP_W-1:0]     hops;
        logic [SEQ_NUM_W-1:0] seq;
    } decision_t;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    logic [ADDR_W-1:0]     src_addr;
    logic [ADDR_W-1:0]     dest_addr;
    logic                  kind;
    logic [SEQ_NUM_W-1:0]  seq_num;
    logic [HOP_W-1:0]      hop_count;
    logic [LINK_W-1:0]     arrived_link;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  out_valid;
    logic                  out_stall;
    logic [ACT_W-1:0]      action;
    logic [MASK_W-1:0]     link_mask;
    logic [HOP_W-1:0]      out_hop_count;
    logic [SEQ_NUM_W-1:0]  out_seq;

    // predictor copy of configuration and peer table
    logic [ADDR_W-1:0]    node_addr;
    logic [LINK_W-1:0]    link_total;
    logic [HOP_W-1:0]     hop_limit;
    logic [ADDR_W-1:0]    peer_addr[TABLE_DEPTH];
    bit                   peer_used[TABLE_DEPTH];
    logic [SEQ_NUM_W-1:0] rx_next[TABLE_DEPTH];
    logic [SEQ_NUM_W-1:0] ack_next[TABLE_DEPTH];
    int                   peers_taken;

    decision_t         pending_decisions[$];
    logic [ADDR_W-1:0] peer_pool[POOL_SIZE];
    int                mismatches;
    int                quiet_cycles;
    int                hold_request;
    bit                bursts_on;

    flood_route_seq_filter_unit i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .src_addr      (src_addr),
        .dest_addr     (dest_addr),
        .kind          (kind),
        .seq_num       (seq_num),
        .hop_count     (hop_count),
        .arrived_link  (arrived_link),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .action        (action),
        .link_mask     (link_mask),
        .out_hop_count (out_hop_count),
        .out_seq       (out_seq)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic int find_peer(logic [ADDR_W-1:0] addr);
        for (int i = 0; i < TABLE_DEPTH; i++)
            if (peer_used[i] && peer_addr[i] == addr)
                return i;
        return -1;
    endfunction

    function automatic int claim_peer(logic [ADDR_W-1:0] addr);
        int idx;
        idx = find_peer(addr);
        if (idx >= 0)
            return idx;
        if (peers_taken >= TABLE_DEPTH)
            return -1;
        idx = peers_taken;
        peers_taken++;
        peer_used[idx] = 1'b1;
        peer_addr[idx] = addr;
        rx_next[idx]   = '0;
        ack_next[idx]  = '0;
        return idx;
    endfunction

    // sequence number the table currently waits for from this source
    function automatic logic [SEQ_NUM_W-1:0] awaited_seq(logic [ADDR_W-1:0] addr, logic is_ack);
        int idx;
        idx = find_peer(addr);
        if (idx < 0)
            return '0;
        return is_ack ? ack_next[idx] : rx_next[idx];
    endfunction

    function automatic decision_t route_decision(header_t h);
        decision_t         d;
        logic [HOP_W-1:0]  hops;
        logic [63:0]       span;
        logic [MASK_W-1:0] every_link;
        logic [MASK_W-1:0] arr_bit;
        int                idx;
        d.act      = ACT_DROP;
        d.mask     = '0;
        d.hops     = '0;
        d.seq      = '0;
        hops       = (h.hops != HOP_MAX) ? h.hops + 8'd1 : h.hops;
        span       = (64'd1 << (int'(link_total) + 1)) - 64'd1;
        every_link = span[MASK_W-1:0] & ~32'd1;
        arr_bit    = 32'd1 << h.link;
        if (h.dest == node_addr)
        begin
            idx = claim_peer(h.src);
            if (idx < 0)
            begin
                d.act = ACT_FULL;
            end
            else if (h.kind == KIND_DATA)
            begin
                if (h.seq == rx_next[idx])
                begin
                    rx_next[idx] = rx_next[idx] + 1'b1;
                    d.act  = ACT_DELIVER;
                    d.mask = arr_bit & every_link;
                    d.seq  = h.seq;
                end
                else
                begin
                    d.act = ACT_IGNORE;
                end
            end
            else
            begin
                if (h.seq == ack_next[idx])
                begin
                    ack_next[idx] = ack_next[idx] + 1'b1;
                    d.act = ACT_ACK_OK;
                end
                else
                begin
                    d.act = ACT_IGNORE;
                end
            end
        end
        else if (hops < hop_limit)
        begin
            d.act  = ACT_FORWARD;
            d.mask = every_link & ~arr_bit;
            d.hops = hops;
            d.seq  = h.seq;
        end
        return d;
    endfunction

    // offer one header, optionally after an idle burst; returns once accepted
    task automatic send_packet(input logic [ADDR_W-1:0] src, input logic [ADDR_W-1:0] dest,
                               input logic pkt_kind, input logic [SEQ_NUM_W-1:0] seq,
                               input logic [HOP_W-1:0] hops, input logic [LINK_W-1:0] link);
        header_t h;
        int      gap;
        h.src  = src;
        h.dest = dest;
        h.kind = pkt_kind;
        h.seq  = seq;
        h.hops = hops;
        h.link = link;
        if (bursts_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 13);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        src_addr     <= src;
        dest_addr    <= dest;
        kind         <= pkt_kind;
        seq_num      <= seq;
        hop_count    <= hops;
        arrived_link <= link;
        in_valid     <= 1'b1;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        pending_decisions.push_back(route_decision(h));
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        while (pending_decisions.size() != 0)
            @(posedge clk);
    endtask

    task automatic reconfigure(input logic [ADDR_W-1:0] own, input logic [LINK_W-1:0] links,
                               input logic [HOP_W-1:0] max_hops);
        wait_for_results();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_OWN_ADDR;
        cfg_data  <= own;
        @(posedge clk);
        cfg_index <= CFG_LINK_COUNT;
        cfg_data  <= CFG_DATA_W'(links);
        @(posedge clk);
        cfg_index <= CFG_MAX_HOPS;
        cfg_data  <= CFG_DATA_W'(max_hops);
        @(posedge clk);
        cfg_we <= 1'b0;
        node_addr  = own;
        link_total = links;
        hop_limit  = max_hops;
        @(posedge clk);
    endtask

    // reset values: own address 0, one link, max hops 4
    task automatic test_reset_defaults();
        send_packet(SRC_A, 32'h0, KIND_DATA, 16'd0, 8'd0, 5'd1);
        send_packet(SRC_A, 32'h0, KIND_DATA, 16'd0, 8'd0, 5'd1);
        send_packet(SRC_A, 32'h0, KIND_ACK, 16'd0, 8'd9, 5'd1);
        send_packet(SRC_A, 32'h0, KIND_ACK, 16'd5, 8'd0, 5'd1);
        send_packet(SRC_B, 32'hFFFF_FFFF, KIND_DATA, 16'hFFFF, 8'd0, 5'd1);
        send_packet(SRC_B, 32'h5, KIND_DATA, 16'd0, 8'd2, 5'd31);
        send_packet(SRC_B, 32'h5, KIND_DATA, 16'd0, 8'd3, 5'd1);
    endtask

    task automatic test_directed_routing();
        reconfigure(32'hFFFF_FFFF, 5'd31, 8'd255);
        send_packet(SRC_C, 32'hFFFF_FFFF, KIND_DATA, 16'd0, 8'd255, 5'd31);
        send_packet(SRC_B, 32'h0, KIND_DATA, 16'h1234, 8'd255, 5'd3);   // saturated hop
        send_packet(SRC_B, 32'h0, KIND_DATA, 16'h00FF, 8'd253, 5'd16);
        send_packet(SRC_B, 32'h0, KIND_ACK, 16'hFF00, 8'd254, 5'd16);
        send_packet(SRC_C, 32'hFFFF_FFFF, KIND_DATA, 16'hFFFF, 8'd0, 5'd2);
        send_packet(SRC_C, 32'hFFFF_FFFF, KIND_ACK, 16'd0, 8'd0, 5'd2);
        send_packet(32'h0, 32'hFFFF_FFFF, KIND_DATA, 16'd0, 8'd7, 5'd5);
        reconfigure(32'h1234_5678, 5'd3, 8'd1);
        send_packet(SRC_B, 32'h0, KIND_DATA, 16'd1, 8'd0, 5'd1);
        reconfigure(32'h1234_5678, 5'd3, 8'd8);
        // arrival link beyond the link count
        send_packet(SRC_B, 32'h0, KIND_DATA, 16'd2, 8'd0, 5'd7);
        send_packet(SRC_A, 32'h1234_5678, KIND_DATA, awaited_seq(SRC_A, KIND_DATA),
                    8'd0, 5'd7);
        reconfigure(32'h1234_5678, 5'd0, 8'd8);
        send_packet(SRC_B, 32'h0, KIND_DATA, 16'd3, 8'd0, 5'd1);
        reconfigure(32'h1234_5678, 5'd5, 8'd0);
        send_packet(SRC_B, 32'h0, KIND_DATA, 16'd4, 8'd0, 5'd1);
    endtask

    // receiver holds off while requests keep coming, so the input side backs up
    task automatic test_output_hold();
        bit saved;
        saved = bursts_on;
        reconfigure(32'h0000_00C3, 5'd31, 8'd200);
        bursts_on    = 1'b0;
        hold_request = HOLD_CYCLES;
        for (int i = 0; i < 10; i++)
        begin
            if (i % 3 == 0)
                send_packet(SRC_A, 32'h0000_00C3, KIND_DATA, awaited_seq(SRC_A, KIND_DATA),
                            8'($urandom), 5'($urandom_range(1, 31)));
            else
                send_packet($urandom, $urandom, 1'($urandom), 16'($urandom), 8'(i),
                            5'($urandom_range(1, 31)));
        end
        wait_for_results();
        bursts_on = saved;
    endtask

    task automatic test_random_traffic();
        logic [ADDR_W-1:0]    src;
        logic [HOP_W-1:0]     hops;
        logic                 pkt_kind;
        logic [SEQ_NUM_W-1:0] seq;
        int                   pick;
        for (int phase = 0; phase < 5; phase++)
        begin
            case (phase)
                0: reconfigure($urandom, 5'd31, 8'd255);
                1: reconfigure(32'h0, 5'd1, 8'd1);
                2: reconfigure(32'hFFFF_FFFF, 5'($urandom_range(1, 31)),
                               8'($urandom_range(2, 16)));
                default: reconfigure($urandom, 5'($urandom_range(1, 31)),
                                     8'($urandom_range(1, 255)));
            endcase
            bursts_on = (phase != 4);
            for (int i = 0; i < 95; i++)
            begin
                pick     = $urandom_range(0, 19);
                pkt_kind = 1'($urandom);
                if (pick < 10)
                begin
                    // mostly in-order traffic from a known set of peers
                    src = peer_pool[$urandom_range(0, POOL_SIZE - 1)];
                    seq = ($urandom_range(0, 6) != 0) ? awaited_seq(src, pkt_kind)
                                                      : 16'($urandom);
                    send_packet(src, node_addr, pkt_kind, seq, 8'($urandom),
                                5'($urandom_range(1, 31)));
                end
                else if (pick < 12)
                begin
                    src = $urandom;
                    send_packet(src, node_addr, pkt_kind, awaited_seq(src, pkt_kind),
                                8'($urandom), 5'($urandom_range(1, 31)));
                end
                else if (pick < 18)
                begin
                    hops = ($urandom_range(0, 1) != 0) ? 8'($urandom)
                                                       : hop_limit - 8'($urandom_range(0, 2));
                    send_packet($urandom, $urandom, pkt_kind, 16'($urandom), hops,
                                5'($urandom_range(1, 31)));
                end
                else
                begin
                    send_packet($urandom, $urandom, pkt_kind, 16'($urandom), 8'($urandom),
                                5'($urandom_range(1, 31)));
                end
            end
        end
    endtask

    // result side: check each accepted result, drive out_stall
    initial
    begin
        decision_t want;
        int        stall_left;
        int        hold_left;
        bit        stall_next;
        stall_left = 0;
        hold_left  = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid === 1'b1 && out_stall === 1'b0)
            begin
                if (pending_decisions.size() == 0)
                begin
                    $error("result with no request outstanding, action %0d", action);
                    mismatches++;
                end
                else
                begin
                    want = pending_decisions.pop_front();
                    if (action !== want.act)
                    begin
                        $error("action: expected %0d, got %0d", want.act, action);
                        mismatches++;
                    end
                    if (link_mask !== want.mask)
                    begin
                        $error("link_mask: expected %h, got %h", want.mask, link_mask);
                        mismatches++;
                    end
                    if (out_hop_count !== want.hops)
                    begin
                        $error("out_hop_count: expected %0d, got %0d",
                               want.hops, out_hop_count);
                        mismatches++;
                    end
                    if (out_seq !== want.seq)
                    begin
                        $error("out_seq: expected %0d, got %0d", want.seq, out_seq);
                        mismatches++;
                    end
                end
            end
            if (hold_request > 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                stall_next = 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                stall_next = 1'b1;
            end
            else if (bursts_on && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(1, 13) - 1;
                stall_next = 1'b1;
            end
            else
            begin
                stall_next = 1'b0;
            end
            out_stall <= stall_next;
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid === 1'b1 && in_stall === 1'b0) ||
            (out_valid === 1'b1 && out_stall === 1'b0))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        in_valid     <= 1'b0;
        src_addr     <= '0;
        dest_addr    <= '0;
        kind         <= KIND_DATA;
        seq_num      <= '0;
        hop_count    <= '0;
        arrived_link <= 5'd1;
        cfg_we       <= 1'b0;
        cfg_index    <= CFG_OWN_ADDR;
        cfg_data     <= '0;
        rst_n        <= 1'b0;
        mismatches   = 0;
        quiet_cycles = 0;
        hold_request = 0;
        bursts_on    = 1'b1;
        node_addr    = '0;
        link_total   = LINK_COUNT_RST;
        hop_limit    = MAX_HOPS_RST;
        peers_taken  = 0;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            peer_used[i] = 1'b0;
            peer_addr[i] = '0;
            rx_next[i]   = '0;
            ack_next[i]  = '0;
        end
        // more peers than table entries, so the table fills during random traffic
        peer_pool[0] = SRC_A;
        peer_pool[1] = SRC_C;
        peer_pool[2] = 32'h0;
        for (int i = 3; i < POOL_SIZE; i++)
            peer_pool[i] = $urandom;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_directed_routing();
        test_output_hold();
        test_random_traffic();

        wait_for_results();
        repeat (DRAIN_TAIL) @(posedge clk);
        if (pending_decisions.size() != 0)
        begin
            $error("%0d results never arrived", pending_decisions.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
